@@ rtl/btp_pkg.sv @@
package btp_pkg;

	localparam int MAP_COLUMNS_DEF = 128;
	localparam int MAP_ROWS_DEF    = 256;

	localparam int PT_W     = 13;
	localparam int CANVAS_W = 12;
	localparam int RX_W     = 11;
	localparam int RY_W     = 11;
	localparam int RW_W     = 7;
	localparam int RH_W     = 5;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_LARGE_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd2;

	localparam logic [CANVAS_W-1:0] CANVAS_WIDTH_RST  = 12'd640;
	localparam logic [CANVAS_W-1:0] CANVAS_HEIGHT_RST = 12'd480;

	localparam int SMALL_CW    = 18;
	localparam int SMALL_CH    = 12;
	localparam int LARGE_CW    = 36;
	localparam int LARGE_CH    = 24;
	localparam int SMALL_JOINT = 2;
	localparam int LARGE_JOINT = 4;

	localparam int COL_MAX = (2**CANVAS_W - 1) / SMALL_CW;
	localparam int ROW_MAX = (2**CANVAS_W - 1) / SMALL_CH;
	localparam int COL_W   = $clog2(COL_MAX + 1);
	localparam int ROW_W   = $clog2(ROW_MAX + 1);

	// x/18 = (x>>1)/9, y/12 = (y>>2)/3, by reciprocal over 2^16; exact below 2^11
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP9_W    = 14;
	localparam int RECIP3_W    = 15;
	localparam logic [RECIP9_W-1:0] RECIP9 = 14'd7282;
	localparam logic [RECIP3_W-1:0] RECIP3 = 15'd21846;

	localparam int EPOCH_W = 8;

	typedef struct packed {
		logic load;
		logic epoch_step;
		logic wipe;
		logic rd_nbr;
		logic commit;
	} btp_cmd_t;

	typedef struct packed {
		logic epoch_full;
		logic on_canvas;
		logic hit;
		logic wipe_last;
	} btp_stat_t;

endpackage

@@ rtl/btp_ram.sv @@
module btp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ rtl/btp_ctrl.sv @@
module btp_ctrl
	import btp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      new_stroke,
	input  btp_stat_t stat,
	output btp_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [3:0] {
		S_WIPE,
		S_IDLE,
		S_DIV,
		S_LIN,
		S_MOD1,
		S_MOD2,
		S_RDC,
		S_RDN,
		S_CHK
	} state_t;

	state_t state_q;
	logic   pending_q;
	logic   done_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && start;
		cmd.epoch_step = cmd.load && new_stroke;
		cmd.wipe       = (state_q == S_WIPE);
		cmd.rd_nbr     = (state_q == S_RDN);
		cmd.commit     = (state_q == S_CHK) && !stat.hit;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_WIPE;
			pending_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_WIPE: begin
					if (stat.wipe_last) begin
						state_q   <= pending_q ? S_DIV : S_IDLE;
						pending_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						if (new_stroke && stat.epoch_full) begin
							state_q   <= S_WIPE;
							pending_q <= 1'b1;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV:  state_q <= S_LIN;
				S_LIN:  state_q <= stat.on_canvas ? S_MOD1 : S_IDLE;
				S_MOD1: state_q <= S_MOD2;
				S_MOD2: state_q <= S_RDC;
				S_RDC:  state_q <= S_RDN;
				S_RDN:  state_q <= S_CHK;
				S_CHK: begin
					state_q <= S_IDLE;
					done_q  <= !stat.hit;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/btp_datapath.sv @@
module btp_datapath
	import btp_pkg::*;
#(
	parameter int MAP_COLUMNS = MAP_COLUMNS_DEF,
	parameter int MAP_ROWS    = MAP_ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [PT_W-1:0]       point_x,
	input  logic [PT_W-1:0]       point_y,
	input  btp_cmd_t              cmd,
	output btp_stat_t             stat,
	output logic [RX_W-1:0]       rect_x,
	output logic [RY_W-1:0]       rect_y,
	output logic [RW_W-1:0]       rect_w,
	output logic [RH_W-1:0]       rect_h
);

	localparam int DEPTH   = MAP_COLUMNS * MAP_ROWS;
	localparam int AW      = $clog2(DEPTH);
	localparam int LIN_MAX = COL_MAX + 1 + (ROW_MAX + 1) * MAP_COLUMNS;
	localparam int LIN_W   = $clog2(LIN_MAX + 1);
	localparam int MOD_S   = LIN_W + AW;
	localparam int QW      = (LIN_W >= AW) ? (LIN_W - AW + 1) : 1;
	localparam int PW      = MOD_S + QW;
	localparam int RW      = ((LIN_W > AW) ? LIN_W : AW) + 1;
	localparam logic [63:0] MOD_K = ((64'd1 << MOD_S) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
	localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

	logic                  large_q;
	logic [CANVAS_W-1:0]   canvas_w_q;
	logic [CANVAS_W-1:0]   canvas_h_q;
	logic [EPOCH_W-1:0]    epoch_q;
	logic [AW-1:0]         wipe_cnt_q;

	logic [PT_W-1:0]       px_q;
	logic [PT_W-1:0]       py_q;
	logic                  inside_q;
	logic [COL_W-1:0]      qx_q;
	logic [ROW_W-1:0]      qy_q;
	logic [LIN_W-1:0]      lin_q;
	logic                  odd_q;
	logic [RX_W-1:0]       cellx_q;
	logic [RY_W-1:0]       celly_q;
	logic [PW-1:0]         prod_q;
	logic [AW-1:0]         addr_q;
	logic                  hit_q;

	logic [5:0]            cw;
	logic [4:0]            ch;
	logic [2:0]            joint;
	logic [RX_W+RECIP9_W-1:0] prodx;
	logic [CANVAS_W-2+RECIP3_W-1:0] prody;
	logic [COL_W-1:0]      col_d;
	logic [ROW_W-1:0]      row_d;
	logic [LIN_W-1:0]      lin_d;
	logic [COL_W+5:0]      cellx_d;
	logic [ROW_W+4:0]      celly_d;
	logic [QW-1:0]         quot;
	logic [RW-1:0]         rem_d;
	logic [AW-1:0]         nbr_addr;
	logic                  nbr_hit;
	logic                  stretch_left;

	logic [AW-1:0]         ram_addr;
	logic                  ram_we;
	logic [EPOCH_W-1:0]    ram_wdata;
	logic [EPOCH_W-1:0]    ram_rdata;

	assign cw    = large_q ? 6'(LARGE_CW) : 6'(SMALL_CW);
	assign ch    = large_q ? 5'(LARGE_CH) : 5'(SMALL_CH);
	assign joint = large_q ? 3'(LARGE_JOINT) : 3'(SMALL_JOINT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			large_q    <= 1'b0;
			canvas_w_q <= CANVAS_WIDTH_RST;
			canvas_h_q <= CANVAS_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LARGE_MODE:    large_q    <= cfg_data[0];
				CFG_CANVAS_WIDTH:  canvas_w_q <= cfg_data;
				CFG_CANVAS_HEIGHT: canvas_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// marks carry the stroke epoch; an old epoch reads as clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q    <= EPOCH_W'(1);
			wipe_cnt_q <= '0;
		end else begin
			if (cmd.epoch_step) begin
				epoch_q <= (epoch_q == '1) ? EPOCH_W'(1) : epoch_q + EPOCH_W'(1);
			end
			if (cmd.wipe) begin
				wipe_cnt_q <= (wipe_cnt_q == ADDR_LAST) ? '0 : wipe_cnt_q + AW'(1);
			end
		end
	end

	assign stat.epoch_full = (epoch_q == '1);
	assign stat.wipe_last  = (wipe_cnt_q == ADDR_LAST);
	assign stat.on_canvas  = inside_q;
	assign stat.hit        = hit_q;

	assign prodx = px_q[CANVAS_W-1:1] * RECIP9;
	assign prody = py_q[CANVAS_W-1:2] * RECIP3;

	always_comb begin
		col_d   = large_q ? (qx_q >> 1) : qx_q;
		row_d   = large_q ? (qy_q >> 1) : qy_q;
		lin_d   = LIN_W'(col_d) + LIN_W'(1)
			+ (LIN_W'(row_d) + LIN_W'(1)) * LIN_W'(MAP_COLUMNS);
		cellx_d = col_d * cw;
		celly_d = row_d * ch;
	end

	assign quot  = prod_q[PW-1:MOD_S];
	assign rem_d = RW'(lin_q) - RW'(quot) * RW'(DEPTH);

	assign nbr_addr = odd_q ? ((addr_q == ADDR_LAST) ? '0 : addr_q + AW'(1))
		: ((addr_q == '0) ? ADDR_LAST : addr_q - AW'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= point_x;
			py_q <= point_y;
		end
		inside_q <= !px_q[PT_W-1] && !py_q[PT_W-1]
			&& (px_q[CANVAS_W-1:0] < canvas_w_q) && (py_q[CANVAS_W-1:0] < canvas_h_q);
		qx_q    <= prodx[RECIP_SHIFT +: COL_W];
		qy_q    <= prody[RECIP_SHIFT +: ROW_W];
		lin_q   <= lin_d;
		odd_q   <= col_d[0] ^ row_d[0];
		cellx_q <= cellx_d[RX_W-1:0];
		celly_q <= celly_d[RY_W-1:0];
		prod_q  <= PW'(lin_q) * PW'(MOD_K);
		addr_q  <= rem_d[AW-1:0];
		hit_q   <= (ram_rdata == epoch_q);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = epoch_q;
		ram_addr  = addr_q;
		priority if (cmd.wipe) begin
			ram_we    = 1'b1;
			ram_wdata = '0;
			ram_addr  = wipe_cnt_q;
		end else if (cmd.commit) begin
			ram_we = 1'b1;
		end else if (cmd.rd_nbr) begin
			ram_addr = nbr_addr;
		end
	end

	btp_ram #(
		.WIDTH(EPOCH_W),
		.DEPTH(DEPTH)
	) u_map (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign nbr_hit      = (ram_rdata == epoch_q);
	assign stretch_left = nbr_hit && !odd_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rect_x <= cellx_q - (stretch_left ? RX_W'(cw) : RX_W'(0));
			rect_y <= celly_q;
			rect_w <= nbr_hit ? (RW_W'(cw) + RW_W'(cw) - RW_W'(joint))
				: (RW_W'(cw) - RW_W'(joint));
			rect_h <= ch - RH_W'(joint);
		end
	end

endmodule

@@ rtl/brick_tile_placer.sv @@
// Brick placer. Pulse start with a point while busy is low; the transaction is taken at
// that edge. A point on the canvas that lands on an unmarked cell gives one rectangle,
// shown for a single cycle with done high after the divide, index, modulo, read and check
// states; busy is already low in that cycle and the receiver cannot hold it off. A point
// off the canvas gives nothing and frees the block after the index state; a point on a
// marked cell gives nothing and frees it after the check. A point's path is divide, cell
// index, two-step modulo over the map depth, then two reads and, if unmarked, a write on
// the single-port cell map. The map is cleared by stroke epoch: after reset, and on every
// 255th new stroke, busy stays high while all MAP_COLUMNS*MAP_ROWS cells are wiped.
// The user must make register writes only while idle; the block does not enforce it.
module brick_tile_placer
	import btp_pkg::*;
#(
	parameter int MAP_COLUMNS = MAP_COLUMNS_DEF,
	parameter int MAP_ROWS    = MAP_ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic                  new_stroke,
	input  logic [PT_W-1:0]       point_x,
	input  logic [PT_W-1:0]       point_y,
	output logic                  done,
	output logic [RX_W-1:0]       rect_x,
	output logic [RY_W-1:0]       rect_y,
	output logic [RW_W-1:0]       rect_w,
	output logic [RH_W-1:0]       rect_h
);

	btp_cmd_t  cmd;
	btp_stat_t stat;

	btp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.new_stroke (new_stroke),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done)
	);

	btp_datapath #(
		.MAP_COLUMNS(MAP_COLUMNS),
		.MAP_ROWS   (MAP_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.point_x   (point_x),
		.point_y   (point_y),
		.cmd       (cmd),
		.stat      (stat),
		.rect_x    (rect_x),
		.rect_y    (rect_y),
		.rect_w    (rect_w),
		.rect_h    (rect_h)
	);

endmodule

@@ tb/brick_tile_placer_tb.sv @@
`timescale 1ns / 1ps

module brick_tile_placer_tb;
	import btp_pkg::*;

	localparam int MAP_DEPTH = MAP_COLUMNS_DEF * MAP_ROWS_DEF;
	localparam int STALL_LIMIT = 200000;

	typedef struct packed {
		logic [RX_W-1:0] x;
		logic [RY_W-1:0] y;
		logic [RW_W-1:0] w;
		logic [RH_W-1:0] h;
	} brick_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_LARGE_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  new_stroke = 1'b0;
	logic [PT_W-1:0]       point_x = '0;
	logic [PT_W-1:0]       point_y = '0;
	logic                  done;
	logic [RX_W-1:0]       rect_x;
	logic [RY_W-1:0]       rect_y;
	logic [RW_W-1:0]       rect_w;
	logic [RH_W-1:0]       rect_h;

	// shadow of the register file
	logic                bricks_large = 1'b0;
	logic [CANVAS_W-1:0] canvas_w = CANVAS_WIDTH_RST;
	logic [CANVAS_W-1:0] canvas_h = CANVAS_HEIGHT_RST;

	// a cell is marked when its stamp equals the current stroke number
	int unsigned cell_stroke [MAP_DEPTH];
	int unsigned stroke_no = 1;

	brick_t brick_q [$];
	brick_t due_brick;
	int     fail_count = 0;
	int     idle_cycles = 0;
	int     gap_max = 3;

	brick_tile_placer DUT (.*);

	always #2 clk = ~clk;

	function automatic bit predict_brick(input logic ns, input logic [PT_W-1:0] px_raw,
		input logic [PT_W-1:0] py_raw, output brick_t b);
		int px, py, cw, chh, joint, col, row, addr, rx, ry, rw, rh;
		cw    = bricks_large ? LARGE_CW : SMALL_CW;
		chh   = bricks_large ? LARGE_CH : SMALL_CH;
		joint = bricks_large ? LARGE_JOINT : SMALL_JOINT;
		px = $signed(px_raw);
		py = $signed(py_raw);
		b = '0;
		if (ns)
			stroke_no++;
		if (px < 0 || py < 0)
			return 1'b0;
		if (px >= int'(canvas_w) || py >= int'(canvas_h))
			return 1'b0;
		col  = px / cw;
		row  = py / chh;
		addr = ((col + 1) + (row + 1) * MAP_COLUMNS_DEF) % MAP_DEPTH;
		if (cell_stroke[addr] == stroke_no)
			return 1'b0;
		cell_stroke[addr] = stroke_no;
		rx = col * cw;
		rw = cw - joint;
		if (((col ^ row) & 1) != 0) begin
			if (cell_stroke[(addr + 1) % MAP_DEPTH] == stroke_no)
				rw = 2 * cw - joint;
		end else if (cell_stroke[(addr + MAP_DEPTH - 1) % MAP_DEPTH] == stroke_no) begin
			rx = rx - cw;
			rw = 2 * cw - joint;
		end
		ry = row * chh;
		rh = chh - joint;
		b.x = rx[RX_W-1:0];
		b.y = ry[RY_W-1:0];
		b.w = rw[RW_W-1:0];
		b.h = rh[RH_W-1:0];
		return 1'b1;
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, 8191)) - 4096;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (brick_q.size() == 0) begin
				$error("rectangle with none pending: x=%0d y=%0d w=%0d h=%0d",
					rect_x, rect_y, rect_w, rect_h);
				fail_count++;
			end else begin
				due_brick = brick_q.pop_front();
				check_field("rect_x", int'(due_brick.x), int'(rect_x));
				check_field("rect_y", int'(due_brick.y), int'(rect_y));
				check_field("rect_w", int'(due_brick.w), int'(rect_w));
				check_field("rect_h", int'(due_brick.h), int'(rect_h));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("brick_tile_placer_tb failed");
			$finish;
		end
	end

	// start stays high across back-to-back transactions
	task automatic send_point(input logic ns, input int x, input int y);
		int gap;
		brick_t b;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			start <= 1'b0;
			do @(posedge clk); while (busy);
			repeat (gap - 1) @(posedge clk);
		end
		start      <= 1'b1;
		new_stroke <= ns;
		point_x    <= x[PT_W-1:0];
		point_y    <= y[PT_W-1:0];
		do @(posedge clk); while (busy);
		if (predict_brick(ns, x[PT_W-1:0], y[PT_W-1:0], b))
			brick_q.push_back(b);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (brick_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_regs(input logic mode, input int w, input int h);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LARGE_MODE;
		cfg_data  <= {11'($urandom), mode};
		@(posedge clk);
		cfg_index <= CFG_CANVAS_WIDTH;
		cfg_data  <= w[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_CANVAS_HEIGHT;
		cfg_data  <= h[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		bricks_large = mode;
		canvas_w     = w[CANVAS_W-1:0];
		canvas_h     = h[CANVAS_W-1:0];
	endtask

	task automatic test_corner_points();
		send_point(1'b1, 0, 0);
		send_point(1'b0, 18, 0);
		send_point(1'b0, 5, 5);
		send_point(1'b0, 36, 0);
		send_point(1'b0, 108, 0);
		send_point(1'b0, 90, 0);
		send_point(1'b0, -1, 5);
		send_point(1'b0, 5, -1);
		send_point(1'b0, 640, 0);
		send_point(1'b0, 0, 480);
		send_point(1'b0, 639, 479);
		send_point(1'b0, -4096, -4096);
		send_point(1'b0, 4095, 4095);
		send_point(1'b0, -4096, 4095);
		send_point(1'b1, 0, 0);
		send_point(1'b0, 0, 12);
	endtask

	// columns past the row pitch alias, the map wraps, and rectangles overflow 11 bits
	task automatic test_wide_canvas();
		drain();
		write_regs(1'b0, 4095, 4095);
		send_point(1'b1, 2286, 12);
		send_point(1'b0, 0, 24);
		send_point(1'b0, 4095, 4095);
		send_point(1'b0, 0, 12);
		send_point(1'b0, 2304, 0);
		send_point(1'b0, 0, 3060);
		send_point(1'b0, 2286, 3048);
	endtask

	task automatic test_closed_canvas();
		drain();
		write_regs(1'b0, 0, 0);
		send_point(1'b1, 0, 0);
		send_point(1'b0, 100, 100);
	endtask

	task automatic test_large_bricks();
		drain();
		write_regs(1'b1, 2048, 2048);
		send_point(1'b1, 0, 0);
		send_point(1'b0, 36, 0);
		send_point(1'b0, 72, 0);
		send_point(1'b0, 2047, 2047);
		send_point(1'b0, 2048, 0);
		send_point(1'b0, 0, 2048);
	endtask

	task automatic test_stroke_walks();
		int mode, w, h, xstep, ystep, x, y, len, sent;
		for (int s = 0; s < 6; s++) begin
			case (s)
				0: begin mode = 0; w = 640; h = 480; end
				1: begin mode = 1; w = 2048; h = 2048; end
				2: begin mode = 0; w = 4095; h = 4095; end
				3: begin mode = 1; w = 1; h = 1; end
				default: begin
					mode = $urandom_range(0, 1);
					w    = $urandom_range(1, 4095);
					h    = $urandom_range(1, 4095);
				end
			endcase
			drain();
			write_regs(mode[0], w, h);
			xstep = mode ? LARGE_CW : SMALL_CW;
			ystep = mode ? LARGE_CH : SMALL_CH;
			sent = 0;
			while (sent < 120) begin
				len     = $urandom_range(1, 40);
				gap_max = $urandom_range(0, 1) ? 3 : 0;
				x = $urandom_range(0, w - 1);
				y = $urandom_range(0, h - 1);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) == 0)
						send_point(1'($urandom_range(0, 1)), any_coord(), any_coord());
					else
						send_point(i == 0, x, y);
					x += int'($urandom_range(0, 2 * xstep)) - xstep;
					y += int'($urandom_range(0, 2 * ystep)) - ystep;
				end
				sent += len;
			end
		end
		gap_max = 3;
	endtask

	// many short strokes over a few cells: old marks must vanish, map clear wraps round
	task automatic test_stroke_churn();
		int len;
		drain();
		write_regs(1'b0, 640, 480);
		for (int k = 0; k < 300; k++) begin
			len     = $urandom_range(1, 3);
			gap_max = $urandom_range(0, 1) ? 3 : 0;
			for (int i = 0; i < len; i++)
				send_point(i == 0, int'($urandom_range(0, 90)), int'($urandom_range(0, 48)));
		end
		gap_max = 3;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_corner_points();
		test_wide_canvas();
		test_closed_canvas();
		test_large_bricks();
		test_stroke_walks();
		test_stroke_churn();
		drain();
		if (fail_count == 0)
			$display("brick_tile_placer_tb passed");
		else
			$display("brick_tile_placer_tb failed");
		$finish;
	end

endmodule
